// ===== rtl/dqpal_pkg.sv =====
// Package for the double-ended queue with palindrome check.
// Holds the command and status codes, the result beat type and the default depth.
// No dependencies.
package dqpal_pkg;

  // Default number of queue entries.
  localparam int DQPAL_DEPTH = 16;

  // Field widths fixed by the block's interface.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes carried on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CHECK      = 3'd4
  } cmd_t;

  // Status codes carried on the result channel.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One result beat as it travels from the sequencer to the output register.
  typedef struct packed {
    status_t              status;
    logic                 is_mirror;
    logic [COUNT_W-1:0]   entry_count;
  } res_t;

endpackage

// ===== rtl/dqpal_if.sv =====
// Valid/ready channel interfaces for the command and result beats.
// Depends on dqpal_pkg for the field widths.
interface dqpal_in_if import dqpal_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dqpal_out_if import dqpal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                is_mirror;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output is_mirror, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input is_mirror, input entry_count,
                  output ready);
endinterface

// ===== rtl/dqpal_ram.sv =====
// Generic synchronous RAM: one write port and two read ports, registered read data.
// No dependencies.
module dqpal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports return data in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/dqpal_seq.sv =====
// Command sequencer: ring pointers, entry count and the pairwise palindrome scan.
// Depends on dqpal_pkg; drives the ports of one dqpal_ram instance.
module dqpal_seq import dqpal_pkg::*; #(
  parameter int DEPTH = DQPAL_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command beat.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VALUE_W-1:0]  in_value,
  // Pending result, taken by the output register.
  output logic                res_valid,
  output res_t                res,
  input  logic                res_take,
  // RAM ports.
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [VALUE_W-1:0]  ram_wdata,
  output logic [AW-1:0]       ram_raddr_a,
  output logic [AW-1:0]       ram_raddr_b,
  input  logic [VALUE_W-1:0]  ram_rdata_a,
  input  logic [VALUE_W-1:0]  ram_rdata_b
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  localparam int SW = CW + 1;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   pairs_r, pairs_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic            miss_r, miss_nxt;
  logic            res_vld_r, res_vld_nxt;
  res_t            res_r, res_nxt;
  logic            accept;
  logic            full;
  logic            empty;
  logic            pair_ne;

  // Slot at a given offset from a base slot, wrapped once around the ring.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    begin
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
        sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
    end
  endfunction

  // Previous and next slot around the ring.
  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    begin
      return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    end
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    begin
      return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    end
  endfunction

  // A new command is taken only while no scan runs and the result slot frees up.
  assign in_ready  = (state_r == S_IDLE) && (!res_vld_r || res_take);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign pair_ne   = (ram_rdata_a != ram_rdata_b);
  assign res_valid = res_vld_r;
  assign res       = res_r;

  // Next-state logic for commands and the scan.
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    pairs_nxt   = pairs_r;
    rd_vld_nxt  = 1'b0;
    miss_nxt    = miss_r;
    res_vld_nxt = res_vld_r && !res_take;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = front_r;
    ram_wdata   = in_value;
    ram_raddr_a = lo_r;
    ram_raddr_b = hi_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.status    = ST_DONE;
          res_nxt.is_mirror = 1'b0;
          res_vld_nxt       = 1'b1;
          unique case (in_cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                front_nxt = slot_dec(front_r);
                ram_we    = 1'b1;
                ram_waddr = slot_dec(front_r);
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(front_r, count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                front_nxt = slot_inc(front_r);
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_CHECK: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                res_nxt.is_mirror = 1'b1;
              end else begin
                // Walk inwards from both ends, one pair per cycle.
                res_vld_nxt = 1'b0;
                lo_nxt      = front_r;
                hi_nxt      = wrap_add(front_r, count_r - CW'(1));
                pairs_nxt   = count_r >> 1;
                miss_nxt    = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          res_nxt.entry_count = COUNT_W'(count_nxt);
        end
      end
      S_SCAN: begin
        // Issue one pair of reads and compare the pair read last cycle.
        rd_vld_nxt = 1'b1;
        lo_nxt     = slot_inc(lo_r);
        hi_nxt     = slot_dec(hi_r);
        pairs_nxt  = pairs_r - CW'(1);
        miss_nxt   = miss_r || (rd_vld_r && pair_ne);
        if (pairs_r == CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last pair arrives; the result slot is known to be free here.
        res_nxt.status      = ST_DONE;
        res_nxt.is_mirror   = !(miss_r || pair_ne);
        res_nxt.entry_count = COUNT_W'(count_r);
        res_vld_nxt         = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pairs_r <= pairs_nxt;
    miss_r  <= miss_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== rtl/deque_with_palindrome_check_unit.sv =====
// Top level of the double-ended queue with palindrome check.
// Depends on dqpal_pkg, dqpal_if, dqpal_ram and dqpal_seq.
//
// A bounded ring-buffer deque of DEPTH signed 32-bit entries held in a RAM with
// one write and two read ports. Every command beat yields exactly one result beat.
// For push, pop and unknown commands the result is registered in the sequencer
// and again in the output register; a new command may follow at once unless that
// result cannot move on to the output. A palindrome check of n entries (n of
// two or more) holds off commands through the scan and drain states, reading one
// pair of entries per cycle through the RAM's two read ports and comparing it in
// the cycle after; an empty queue or a single entry answers at once. One further
// command is taken while a result waits on the output. The RAM is not cleared
// after reset and needs no warm-up: only written entries are read.
module deque_with_palindrome_check_unit import dqpal_pkg::*; #(
  parameter int DEPTH = DQPAL_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dqpal_in_if.sink    in_ch,
  dqpal_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic               res_valid;
  res_t               res;
  logic               res_take;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr_a;
  logic [AW-1:0]      ram_raddr_b;
  logic [VALUE_W-1:0] ram_rdata_a;
  logic [VALUE_W-1:0] ram_rdata_b;
  logic               out_vld_r, out_vld_nxt;
  res_t               out_res_r, out_res_nxt;

  // Entry storage.
  dqpal_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Command sequencer.
  dqpal_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_value    (in_ch.value),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  // Output register: loads a pending result whenever its slot is empty or draining.
  assign res_take = res_valid && (!out_vld_r || out_ch.ready);

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_res_nxt = out_res_r;
    if (res_take) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // Result channel.
  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.is_mirror   = out_res_r.is_mirror;
  assign out_ch.entry_count = out_res_r.entry_count;

endmodule
